// ===== rtl/ropp_pkg.sv =====
`default_nettype none
package ropp_pkg;

  localparam int DATA_W     = 32;
  localparam int SCALE_W    = 40;
  localparam int STR_W      = 17;
  localparam int CH_W       = 6;
  localparam int HOP_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int HISTORY_DEPTH_DEF = 31;
  localparam int WARMUP_COUNT_DEF  = 8;

  // 8.8956 in Q16
  localparam logic [19:0] SCALE_FACTOR_Q16 = 20'd582982;
  localparam logic [STR_W-1:0] ONE_Q16 = 17'h10000;

  localparam logic [CFG_IDX_W-1:0] REG_HOP_LENGTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_OFFSET = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_LENGTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ONSET_GAP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_ID    = 3'd4;

  typedef struct packed {
    logic insert;
    logic load_val;
    logic load_dev;
    logic rotate;
  } cell_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/ropp_in_if.sv =====
`default_nettype none
interface ropp_in_if;
  import ropp_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] novelty;
  logic              novelty_invalid;
  modport source (output valid, novelty, novelty_invalid, input ready);
  modport sink (input valid, novelty, novelty_invalid, output ready);
endinterface
`default_nettype wire

// ===== rtl/ropp_out_if.sv =====
`default_nettype none
interface ropp_out_if;
  import ropp_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] onset_position;
  logic [STR_W-1:0]  onset_strength;
  logic [CH_W-1:0]   onset_channel;
  modport source (output valid, onset_position, onset_strength, onset_channel, input ready);
  modport sink (input valid, onset_position, onset_strength, onset_channel, output ready);
endinterface
`default_nettype wire

// ===== rtl/ropp_cfg_if.sv =====
`default_nettype none
interface ropp_cfg_if;
  import ropp_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/ropp_cell.sv =====
`default_nettype none
module ropp_cell (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire ropp_pkg::cell_ctl_t ctl,
  input  wire [ropp_pkg::DATA_W-1:0] bg,
  input  wire [ropp_pkg::DATA_W-1:0] head,
  input  wire [ropp_pkg::DATA_W-1:0] sh_val_i,
  input  wire                      sh_vld_i,
  input  wire [ropp_pkg::DATA_W-1:0] rot_val_i,
  input  wire                      rot_vld_i,
  output logic [ropp_pkg::DATA_W-1:0] hist_o,
  output logic                     vld_o,
  output logic [ropp_pkg::DATA_W-1:0] rot_val_o,
  output logic                     rot_vld_o,
  output logic                     lt_o,
  output logic                     le_o
);
  import ropp_pkg::*;

  logic [DATA_W-1:0] hist_r, key_r, rot_r, dev;
  logic              vld_r, rvld_r;

  assign dev = (hist_r >= bg) ? hist_r - bg : bg - hist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      rvld_r <= 1'b0;
    end else begin
      if (ctl.insert) begin
        hist_r <= sh_val_i;
        vld_r  <= sh_vld_i;
      end
      if (ctl.load_val) begin
        key_r  <= hist_r;
        rot_r  <= hist_r;
        rvld_r <= vld_r;
      end else if (ctl.load_dev) begin
        key_r  <= dev;
        rot_r  <= dev;
        rvld_r <= vld_r;
      end else if (ctl.rotate) begin
        rot_r  <= rot_val_i;
        rvld_r <= rot_vld_i;
      end
    end
  end

  assign hist_o    = hist_r;
  assign vld_o     = vld_r;
  assign rot_val_o = rot_r;
  assign rot_vld_o = rvld_r;
  assign lt_o      = vld_r & (key_r < head);
  assign le_o      = vld_r & (key_r <= head);

endmodule
`default_nettype wire

// ===== rtl/ropp_div.sv =====
`default_nettype none
module ropp_div (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        start,
  input  wire [ropp_pkg::DATA_W-1:0]  diff,
  input  wire [ropp_pkg::SCALE_W-1:0] scale,
  output logic                       done,
  output logic [ropp_pkg::STR_W-1:0]  strength
);
  import ropp_pkg::*;

  localparam int REM_W = DATA_W + 16;
  localparam int DEN_W = SCALE_W + 17;
  localparam int Q_W   = 18;

  logic [REM_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [Q_W-1:0]   q_r;
  logic [4:0]       step_r;
  logic             busy_r, done_r, sat_r, zero_r;
  logic             fits;

  assign fits = {{(DEN_W-REM_W){1'b0}}, rem_r} >= den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      rem_r  <= {diff, 16'b0};
      den_r  <= {scale, 17'b0};
      q_r    <= '0;
      step_r <= 5'd0;
      zero_r <= (scale == '0);
      // quotient would need more than 18 bits
      sat_r  <= ({{(SCALE_W-DATA_W+2){1'b0}}, diff, 16'b0} >= {scale, 18'b0});
      busy_r <= (scale != '0);
      done_r <= (scale == '0);
    end else if (busy_r) begin
      if (fits) rem_r <= rem_r - REM_W'(den_r);
      q_r    <= {q_r[Q_W-2:0], fits};
      den_r  <= den_r >> 1;
      step_r <= step_r + 5'd1;
      if (step_r == 5'(Q_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign done = done_r;
  always_comb begin
    if (zero_r || sat_r || q_r > Q_W'(ONE_Q16)) strength = ONE_Q16;
    else strength = q_r[STR_W-1:0];
  end

endmodule
`default_nettype wire

// ===== rtl/robust_onset_peak_picker.sv =====
// Robust onset peak picker: median / MAD adaptive threshold over recent novelty.
// in_ch takes one novelty word per hop (Q16.16, invalid flag forces zero).
// out_ch gives one onset word (frame, Q1.16 strength, channel) when the word
// held one hop back is a local peak above background + scale/2.
// cfg_ch writes hop length, window offset, source length, onset gap and
// channel id by index 0..4; it is always ready, other indexes are dropped.
// For each input word the history sits in a row of cells whose working
// copies rotate past a head, one rank test per cycle, once for the median
// and once for the deviation. Strength comes from a divider running
// alongside those passes. An onset enters an output register when it is
// decided and stays there until taken; the next word is accepted meanwhile.
// A new onset waits for that register to drain if the receiver stalls.
// Reset (rst_n, synchronous) restores the register defaults and empties the
// history; no clearing pass is needed.
`default_nettype none
module robust_onset_peak_picker #(
  parameter int HISTORY_DEPTH = ropp_pkg::HISTORY_DEPTH_DEF,
  parameter int WARMUP_COUNT  = ropp_pkg::WARMUP_COUNT_DEF
) (
  input wire         clk,
  input wire         rst_n,
  ropp_in_if.sink    in_ch,
  ropp_out_if.source out_ch,
  ropp_cfg_if.sink   cfg_ch
);
  import ropp_pkg::*;

  localparam int CW = $clog2(HISTORY_DEPTH + 1);
  localparam int PW = $clog2(HISTORY_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD1, S_PASS1, S_LOAD2, S_PASS2, S_MUL, S_SCL, S_DECIDE
  } state_t;

  state_t state_r;

  logic [HOP_W-1:0]   hop_len_r, win_off_r;
  logic [DATA_W-1:0]  src_len_r, min_dist_r;
  logic [CH_W-1:0]    chan_r;

  logic [DATA_W-1:0]  nov_r, pos_r, lo_r, hi_r, bg_r, mad_r;
  logic [51:0]        prod_r;
  logic [SCALE_W-1:0] scale_r;
  logic [CW-1:0]      hcnt_r;
  logic [PW-1:0]      pcnt_r;
  logic [1:0]         fill_r;
  logic [DATA_W-1:0]  prior_r, cand_nov_r, cand_bg_r, cand_pos_r;
  logic [SCALE_W-1:0] cand_scale_r;
  logic [DATA_W-1:0]  last_pos_r, hop_pos_r;
  logic               seen_r;

  logic               out_valid_r;
  logic [DATA_W-1:0]  out_pos_r;
  logic [STR_W-1:0]   out_str_r;
  logic [CH_W-1:0]    out_ch_r;

  // cell row
  cell_ctl_t                 ctl;
  logic [DATA_W-1:0]         cell_bg;
  logic [DATA_W-1:0]         hist  [HISTORY_DEPTH];
  logic [DATA_W-1:0]         rotv  [HISTORY_DEPTH];
  logic [HISTORY_DEPTH-1:0]  vld, rvld, ltv, lev;
  logic [DATA_W-1:0]         head;

  logic [DATA_W:0] mid_sum;
  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};

  assign head    = rotv[0];
  // median of the first pass, valid while the deviations load
  assign cell_bg = mid_sum[DATA_W:1];

  for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
    localparam int NXT = (i + 1) % HISTORY_DEPTH;
    logic [DATA_W-1:0] sh_val;
    logic              sh_vld;
    if (i == 0) begin : g_first
      assign sh_val = nov_r;
      assign sh_vld = 1'b1;
    end else begin : g_rest
      assign sh_val = hist[i-1];
      assign sh_vld = vld[i-1];
    end
    ropp_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .bg        (cell_bg),
      .head      (head),
      .sh_val_i  (sh_val),
      .sh_vld_i  (sh_vld),
      .rot_val_i (rotv[NXT]),
      .rot_vld_i (rvld[NXT]),
      .hist_o    (hist[i]),
      .vld_o     (vld[i]),
      .rot_val_o (rotv[i]),
      .rot_vld_o (rvld[i]),
      .lt_o      (ltv[i]),
      .le_o      (lev[i])
    );
  end

  // rank test of the head word
  logic [CW-1:0] n_lt, n_le, k_hi, k_lo;
  logic          hit_lo, hit_hi;
  assign n_lt   = CW'($countones(ltv));
  assign n_le   = CW'($countones(lev));
  assign k_hi   = hcnt_r >> 1;
  assign k_lo   = hcnt_r[0] ? k_hi : k_hi - CW'(1);
  assign hit_lo = rvld[0] && (n_lt <= k_lo) && (k_lo < n_le);
  assign hit_hi = rvld[0] && (n_lt <= k_hi) && (k_hi < n_le);

  // strength divider for the held candidate
  logic             div_start, div_done;
  logic [STR_W-1:0] div_str;
  assign div_start = in_ch.valid && in_ch.ready;
  ropp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .diff     (cand_nov_r - cand_bg_r),
    .scale    (cand_scale_r),
    .done     (div_done),
    .strength (div_str)
  );

  // accept-time position
  logic [DATA_W:0]   pos_sum;
  logic [DATA_W-1:0] pos_sat, pos_clamp;
  assign pos_sum   = {1'b0, hop_pos_r} + {{(DATA_W-HOP_W+1){1'b0}}, win_off_r};
  assign pos_sat   = pos_sum[DATA_W] ? '1 : pos_sum[DATA_W-1:0];
  assign pos_clamp = (src_len_r != '0 && pos_sat >= src_len_r) ? src_len_r - 1'b1 : pos_sat;

  // decision on the held candidate
  logic [CW-1:0]     hcnt_nxt;
  logic [DATA_W:0]   hop_sum;
  logic [SCALE_W:0]  thr_rhs, thr_lhs;
  logic              is_peak, far, produce;
  assign hcnt_nxt = (hcnt_r == CW'(HISTORY_DEPTH)) ? hcnt_r : hcnt_r + CW'(1);
  assign thr_lhs  = (SCALE_W+1)'({cand_nov_r, 1'b0});
  assign thr_rhs  = (SCALE_W+1)'({cand_bg_r, 1'b0}) + {1'b0, cand_scale_r};
  assign is_peak  = (fill_r == 2'd2) && (32'(hcnt_nxt) >= 32'(WARMUP_COUNT)) &&
                    (cand_nov_r > prior_r) && (cand_nov_r >= nov_r) &&
                    (thr_lhs > thr_rhs) && (div_str != '0);
  assign far      = !seen_r || (cand_pos_r >= last_pos_r &&
                    cand_pos_r - last_pos_r >= min_dist_r);
  assign produce  = is_peak && far;
  assign hop_sum  = {1'b0, hop_pos_r} + {{(DATA_W-HOP_W+1){1'b0}}, hop_len_r};

  logic decide_go;
  assign decide_go = (state_r == S_DECIDE) && div_done &&
                     !(produce && out_valid_r && !out_ch.ready);

  always_comb begin
    ctl          = '0;
    ctl.load_val = (state_r == S_LOAD1);
    ctl.load_dev = (state_r == S_LOAD2);
    ctl.rotate   = (state_r == S_PASS1) || (state_r == S_PASS2);
    ctl.insert   = decide_go;
  end

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      hop_len_r    <= 16'd512;
      win_off_r    <= 16'd512;
      src_len_r    <= '0;
      min_dist_r   <= 32'd2205;
      chan_r       <= '0;
      hcnt_r       <= '0;
      fill_r       <= '0;
      prior_r      <= '0;
      cand_nov_r   <= '0;
      cand_bg_r    <= '0;
      cand_scale_r <= '0;
      cand_pos_r   <= '0;
      last_pos_r   <= '0;
      seen_r       <= 1'b0;
      hop_pos_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          REG_HOP_LENGTH:    hop_len_r  <= cfg_ch.data[HOP_W-1:0];
          REG_WINDOW_OFFSET: win_off_r  <= cfg_ch.data[HOP_W-1:0];
          REG_SOURCE_LENGTH: src_len_r  <= cfg_ch.data;
          REG_ONSET_GAP:     min_dist_r <= cfg_ch.data;
          REG_CHANNEL_ID:    chan_r     <= cfg_ch.data[CH_W-1:0];
          default: ;
        endcase
      end
      if (decide_go && produce) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            nov_r   <= in_ch.novelty_invalid ? '0 : in_ch.novelty;
            pos_r   <= pos_clamp;
            state_r <= S_LOAD1;
          end
        end
        S_LOAD1: begin
          lo_r    <= '0;
          hi_r    <= '0;
          pcnt_r  <= '0;
          state_r <= S_PASS1;
        end
        S_PASS1: begin
          if (hit_lo) lo_r <= head;
          if (hit_hi) hi_r <= head;
          pcnt_r <= pcnt_r + PW'(1);
          if (pcnt_r == PW'(HISTORY_DEPTH - 1)) state_r <= S_LOAD2;
        end
        S_LOAD2: begin
          bg_r    <= mid_sum[DATA_W:1];
          lo_r    <= '0;
          hi_r    <= '0;
          pcnt_r  <= '0;
          state_r <= S_PASS2;
        end
        S_PASS2: begin
          if (hit_lo) lo_r <= head;
          if (hit_hi) hi_r <= head;
          pcnt_r <= pcnt_r + PW'(1);
          if (pcnt_r == PW'(HISTORY_DEPTH - 1)) state_r <= S_MUL;
        end
        S_MUL: begin
          mad_r   <= mid_sum[DATA_W:1];
          state_r <= S_SCL;
        end
        S_SCL: begin
          prod_r  <= 52'(mad_r) * 52'(SCALE_FACTOR_Q16);
          state_r <= S_DECIDE;
        end
        S_DECIDE: begin
          if (decide_go) begin
            if (produce) begin
              out_pos_r   <= cand_pos_r;
              out_str_r   <= div_str;
              out_ch_r    <= chan_r;
              last_pos_r  <= cand_pos_r;
              seen_r      <= 1'b1;
            end
            if (fill_r != 2'd0) prior_r <= cand_nov_r;
            if (fill_r != 2'd2) fill_r <= fill_r + 2'd1;
            hcnt_r       <= hcnt_nxt;
            cand_nov_r   <= nov_r;
            cand_bg_r    <= bg_r;
            cand_scale_r <= SCALE_W'((prod_r + 52'd32768) >> 16);
            cand_pos_r   <= pos_r;
            hop_pos_r    <= hop_sum[DATA_W] ? '1 : hop_sum[DATA_W-1:0];
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.onset_position = out_pos_r;
  assign out_ch.onset_strength = out_str_r;
  assign out_ch.onset_channel  = out_ch_r;

endmodule
`default_nettype wire
